[design/assert_macros.svh]
// -----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the ROI window block. Define NO_ASSERTIONS to drop
// every check from the build.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every sampled clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// Expression must never be true at a sampled clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

[design/rwq_pkg.sv]
// -----------------------------------------------------------------------------
// rwq_pkg
// Shared types and constants of the ROI window block.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rwq_pkg;

	localparam int COORD_W    = 15;
	localparam int PIX_W      = 11;
	localparam int SCALE_W    = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_SCALE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SCALE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT_PX = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd4;

	// Reset values
	localparam logic [SCALE_W-1:0] RST_WIDTH_SCALE   = 8'd160;
	localparam logic [SCALE_W-1:0] RST_HEIGHT_SCALE  = 8'd80;
	localparam logic [PIX_W-1:0]   RST_MIN_HEIGHT_PX = 11'd50;
	localparam logic [PIX_W-1:0]   RST_FRAME_WIDTH   = 11'd1280;
	localparam logic [PIX_W-1:0]   RST_FRAME_HEIGHT  = 11'd1024;

	typedef struct packed {
		logic               op;
		logic [COORD_W-1:0] c0_x;
		logic [COORD_W-1:0] c0_y;
		logic [COORD_W-1:0] c1_x;
		logic [COORD_W-1:0] c1_y;
		logic [COORD_W-1:0] c2_x;
		logic [COORD_W-1:0] c2_y;
		logic [COORD_W-1:0] c3_x;
		logic [COORD_W-1:0] c3_y;
	} item_t;

	typedef struct packed {
		logic [PIX_W-1:0] left;
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] right;
		logic [PIX_W-1:0] bottom;
	} result_t;

	typedef struct packed {
		logic [SCALE_W-1:0] width_scale;
		logic [SCALE_W-1:0] height_scale;
		logic [PIX_W-1:0]   min_height_px;
		logic [PIX_W-1:0]   frame_width;
		logic [PIX_W-1:0]   frame_height;
	} cfg_t;

endpackage

[design/rwq_prep.sv]
// -----------------------------------------------------------------------------
// rwq_prep
// Front end: corner sums, edge difference magnitudes, squares and radicands.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rwq_prep #(
	parameter int CW = 15,
	parameter int SW = 17,
	parameter int DW = 16,
	parameter int QW = 33
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           src_valid,
	input  rwq_pkg::item_t src_item,
	output logic           dst_valid,
	output logic           dst_op,
	output logic [SW-1:0]  dst_sx,
	output logic [SW-1:0]  dst_sy,
	output logic [QW-1:0]  dst_qw,
	output logic [QW-1:0]  dst_qh
);
	import rwq_pkg::*;

	logic [CW-1:0]        x0, y0, x1, y1, x2, y2, x3, y3;
	logic signed [SW-1:0] dwx, dwy, dhx, dhy;

	logic          valid_s1, valid_s2, valid_s3;
	logic          op_s1, op_s2, op_s3;
	logic [SW-1:0] sx_s1, sy_s1, sx_s2, sy_s2, sx_s3, sy_s3;
	logic [DW-1:0] awx_s1, awy_s1, ahx_s1, ahy_s1;
	logic [2*DW-1:0] swx_s2, swy_s2, shx_s2, shy_s2;
	logic [QW-1:0] qw_s3, qh_s3;

	function automatic logic [DW-1:0] mag(input logic signed [SW-1:0] d);
		mag = d[SW-1] ? DW'(-d) : DW'(d);
	endfunction

	always_comb begin
		x0 = src_item.c0_x[CW-1:0];
		y0 = src_item.c0_y[CW-1:0];
		x1 = src_item.c1_x[CW-1:0];
		y1 = src_item.c1_y[CW-1:0];
		x2 = src_item.c2_x[CW-1:0];
		y2 = src_item.c2_y[CW-1:0];
		x3 = src_item.c3_x[CW-1:0];
		y3 = src_item.c3_y[CW-1:0];
		// width vector: c1 + c2 - c0 - c3, height vector: c2 + c3 - c1 - c0
		dwx = $signed(SW'(x1) + SW'(x2)) - $signed(SW'(x0) + SW'(x3));
		dwy = $signed(SW'(y1) + SW'(y2)) - $signed(SW'(y0) + SW'(y3));
		dhx = $signed(SW'(x2) + SW'(x3)) - $signed(SW'(x1) + SW'(x0));
		dhy = $signed(SW'(y2) + SW'(y3)) - $signed(SW'(y1) + SW'(y0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= src_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		op_s1  <= src_item.op;
		sx_s1  <= SW'(x0) + SW'(x1) + SW'(x2) + SW'(x3);
		sy_s1  <= SW'(y0) + SW'(y1) + SW'(y2) + SW'(y3);
		awx_s1 <= mag(dwx);
		awy_s1 <= mag(dwy);
		ahx_s1 <= mag(dhx);
		ahy_s1 <= mag(dhy);

		op_s2  <= op_s1;
		sx_s2  <= sx_s1;
		sy_s2  <= sy_s1;
		swx_s2 <= (2*DW)'(awx_s1) * (2*DW)'(awx_s1);
		swy_s2 <= (2*DW)'(awy_s1) * (2*DW)'(awy_s1);
		shx_s2 <= (2*DW)'(ahx_s1) * (2*DW)'(ahx_s1);
		shy_s2 <= (2*DW)'(ahy_s1) * (2*DW)'(ahy_s1);

		op_s3 <= op_s2;
		sx_s3 <= sx_s2;
		sy_s3 <= sy_s2;
		qw_s3 <= QW'(swx_s2) + QW'(swy_s2);
		qh_s3 <= QW'(shx_s2) + QW'(shy_s2);
	end

	assign dst_valid = valid_s3;
	assign dst_op    = op_s3;
	assign dst_sx    = sx_s3;
	assign dst_sy    = sy_s3;
	assign dst_qw    = qw_s3;
	assign dst_qh    = qh_s3;

endmodule

[design/rwq_sqrt_stage.sv]
// -----------------------------------------------------------------------------
// rwq_sqrt_stage
// One root bit of the width and height square roots, with side data.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rwq_sqrt_stage #(
	parameter int QW     = 33,
	parameter int RW     = 17,
	parameter int BIT    = 16,
	parameter int SIDE_W = 35
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	input  logic [SIDE_W-1:0] src_side,
	input  logic [QW-1:0]     src_rem_w,
	input  logic [RW-1:0]     src_root_w,
	input  logic [QW-1:0]     src_rem_h,
	input  logic [RW-1:0]     src_root_h,
	output logic              dst_valid,
	output logic [SIDE_W-1:0] dst_side,
	output logic [QW-1:0]     dst_rem_w,
	output logic [RW-1:0]     dst_root_w,
	output logic [QW-1:0]     dst_rem_h,
	output logic [RW-1:0]     dst_root_h
);
	import rwq_pkg::*;

	localparam int TW = QW + 1;

	logic [TW-1:0]     trial_w, trial_h;
	logic              take_w, take_h;
	logic              valid_s1;
	logic [SIDE_W-1:0] side_s1;
	logic [QW-1:0]     rem_w_s1, rem_h_s1;
	logic [RW-1:0]     root_w_s1, root_h_s1;

	// (root + 2^BIT)^2 - root^2, root holding only the bits above BIT
	function automatic logic [TW-1:0] trial(input logic [RW-1:0] r);
		trial = (TW'(r) << (BIT + 1)) | (TW'(1) << (2 * BIT));
	endfunction

	always_comb begin
		trial_w = trial(src_root_w);
		trial_h = trial(src_root_h);
		take_w  = TW'(src_rem_w) >= trial_w;
		take_h  = TW'(src_rem_h) >= trial_h;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		side_s1   <= src_side;
		rem_w_s1  <= take_w ? QW'(TW'(src_rem_w) - trial_w) : src_rem_w;
		root_w_s1 <= take_w ? (src_root_w | (RW'(1) << BIT)) : src_root_w;
		rem_h_s1  <= take_h ? QW'(TW'(src_rem_h) - trial_h) : src_rem_h;
		root_h_s1 <= take_h ? (src_root_h | (RW'(1) << BIT)) : src_root_h;
	end

	assign dst_valid  = valid_s1;
	assign dst_side   = side_s1;
	assign dst_rem_w  = rem_w_s1;
	assign dst_root_w = root_w_s1;
	assign dst_rem_h  = rem_h_s1;
	assign dst_root_h = root_h_s1;

endmodule

[design/rwq_window.sv]
// -----------------------------------------------------------------------------
// rwq_window
// Back end: height floor, expansion products, edge offset and frame clamp.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rwq_window #(
	parameter int SW   = 17,
	parameter int RW   = 17,
	parameter int FRAC = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rwq_pkg::cfg_t    cfg,
	input  logic             src_valid,
	input  logic             src_op,
	input  logic [SW-1:0]    src_sx,
	input  logic [SW-1:0]    src_sy,
	input  logic [RW-1:0]    src_wlen,
	input  logic [RW-1:0]    src_hlen,
	output logic             dst_valid,
	output rwq_pkg::result_t dst_result
);
	import rwq_pkg::*;

	localparam int HMW = PIX_W + FRAC + 1;
	localparam int HW  = (RW > HMW) ? RW : HMW;
	localparam int PW  = HW + SCALE_W;
	localparam int BW  = SW + 3;
	localparam int EW  = ((BW > PW) ? BW : PW) + 1;
	localparam int SH  = FRAC + 5;
	localparam int PXW = EW - SH;
	localparam int CLW = (PXW > PIX_W) ? PXW : PIX_W;

	logic [HW-1:0] hmin, hraw;
	logic [EW-1:0] bx, by, ox, oy;
	result_t       win;

	logic          valid_s1, valid_s2, valid_s3;
	logic          op_s1, op_s2;
	logic [SW-1:0] sx_s1, sy_s1, sx_s2, sy_s2;
	logic [HW-1:0] wlen_s1, hlen_s1;
	logic [PW-1:0] ox_s2, oy_s2;
	result_t       res_s3;

	// floor to whole pixels, clamp to [0, limit]
	function automatic logic [PIX_W-1:0] clamp_px(input logic [EW-1:0] m,
			input logic neg, input logic [PIX_W-1:0] limit);
		logic [PXW-1:0] p;
		p = m[EW-1:SH];
		if (neg) begin
			clamp_px = '0;
		end else if (CLW'(p) > CLW'(limit)) begin
			clamp_px = limit;
		end else begin
			clamp_px = PIX_W'(p);
		end
	endfunction

	always_comb begin
		hmin = HW'(cfg.min_height_px) << (FRAC + 1);
		hraw = HW'(src_hlen);
		bx   = EW'({sx_s2, 3'b000});
		by   = EW'({sy_s2, 3'b000});
		ox   = EW'(ox_s2);
		oy   = EW'(oy_s2);
		win.left   = clamp_px(bx - ox, bx < ox, cfg.frame_width);
		win.top    = clamp_px(by - oy, by < oy, cfg.frame_height);
		win.right  = clamp_px(bx + ox, 1'b0, cfg.frame_width);
		win.bottom = clamp_px(by + oy, 1'b0, cfg.frame_height);
		if (op_s2) begin
			win.left   = '0;
			win.top    = '0;
			win.right  = cfg.frame_width;
			win.bottom = cfg.frame_height;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= src_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		op_s1   <= src_op;
		sx_s1   <= src_sx;
		sy_s1   <= src_sy;
		wlen_s1 <= HW'(src_wlen);
		hlen_s1 <= (hraw < hmin) ? hmin : hraw;

		op_s2 <= op_s1;
		sx_s2 <= sx_s1;
		sy_s2 <= sy_s1;
		ox_s2 <= PW'(wlen_s1) * PW'(cfg.width_scale);
		oy_s2 <= PW'(hlen_s1) * PW'(cfg.height_scale);

		res_s3 <= win;
	end

	assign dst_valid  = valid_s3;
	assign dst_result = res_s3;

endmodule

[design/roi_window_from_quad_top.sv]
// -----------------------------------------------------------------------------
// roi_window_from_quad_top
// Search window from the four corners of a detected quadrilateral.
// -----------------------------------------------------------------------------
// Usage:
//   Drive an item (op and four corners, unsigned fixed point) on item and
//   raise start; the item is taken at a clock edge where start is high and
//   busy is low. Busy is high only in the first cycle after reset.
//   The window (left, top, right, bottom in whole pixels) shows on result
//   for exactly one cycle with done high. The receiver cannot hold it off.
//   Three front-end stages, one stage per root bit of the two square roots,
//   three back-end stages. One item per cycle once busy is low, set by the
//   fully pipelined root chain; items never wait on each other.
//   Registers are written through cfg_we / cfg_idx / cfg_data; the user must
//   write them only while no item is in flight, the block does not enforce it.
//   Reset loads the default ratios, minimum height and frame size and
//   empties the pipeline; nothing else needs clearing.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module roi_window_from_quad_top #(
	parameter int COORD_FRAC_BITS = 4,
	parameter int COORD_INT_BITS  = 11
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  rwq_pkg::item_t                     item,
	output logic                               done,
	output rwq_pkg::result_t                   result,
	input  logic                               cfg_we,
	input  logic [rwq_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [rwq_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import rwq_pkg::*;

	// Coordinates use only the low integer + fraction bits of each field.
	localparam int NW     = COORD_INT_BITS + COORD_FRAC_BITS;
	localparam int CW     = (NW > COORD_W) ? COORD_W : NW;
	localparam int SW     = CW + 2;          // corner sum
	localparam int DW     = CW + 1;          // edge difference magnitude
	localparam int QW     = 2 * DW + 1;      // radicand
	localparam int RW     = DW + 1;          // root
	localparam int SIDE_W = 1 + 2 * SW;      // op and corner sums riding along
	localparam int LAT    = RW + 6;

	cfg_t cfg_q;
	logic busy_q;
	logic accept;

	// front end -> root chain
	logic          pre_valid, pre_op;
	logic [SW-1:0] pre_sx, pre_sy;
	logic [QW-1:0] pre_qw, pre_qh;

	// root chain taps, index 0 is the chain input
	logic              rt_valid [RW+1];
	logic [SIDE_W-1:0] rt_side  [RW+1];
	logic [QW-1:0]     rt_rem_w [RW+1];
	logic [RW-1:0]     rt_root_w[RW+1];
	logic [QW-1:0]     rt_rem_h [RW+1];
	logic [RW-1:0]     rt_root_h[RW+1];

	logic          bk_op;
	logic [SW-1:0] bk_sx, bk_sy;

	assign accept = start && !busy;
	assign busy   = busy_q;

	// Hold busy for one cycle after reset, then accept every cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	// Register file; writes beyond the last index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width_scale   <= RST_WIDTH_SCALE;
			cfg_q.height_scale  <= RST_HEIGHT_SCALE;
			cfg_q.min_height_px <= RST_MIN_HEIGHT_PX;
			cfg_q.frame_width   <= RST_FRAME_WIDTH;
			cfg_q.frame_height  <= RST_FRAME_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_WIDTH_SCALE:   cfg_q.width_scale   <= cfg_data[SCALE_W-1:0];
				CFG_HEIGHT_SCALE:  cfg_q.height_scale  <= cfg_data[SCALE_W-1:0];
				CFG_MIN_HEIGHT_PX: cfg_q.min_height_px <= cfg_data[PIX_W-1:0];
				CFG_FRAME_WIDTH:   cfg_q.frame_width   <= cfg_data[PIX_W-1:0];
				CFG_FRAME_HEIGHT:  cfg_q.frame_height  <= cfg_data[PIX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sums, difference magnitudes, squares and radicands.
	rwq_prep #(
		.CW(CW),
		.SW(SW),
		.DW(DW),
		.QW(QW)
	) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(accept),
		.src_item (item),
		.dst_valid(pre_valid),
		.dst_op   (pre_op),
		.dst_sx   (pre_sx),
		.dst_sy   (pre_sy),
		.dst_qw   (pre_qw),
		.dst_qh   (pre_qh)
	);

	// Seed the root chain: empty root, full radicand as remainder.
	assign rt_valid[0]  = pre_valid;
	assign rt_side[0]   = {pre_op, pre_sx, pre_sy};
	assign rt_rem_w[0]  = pre_qw;
	assign rt_root_w[0] = '0;
	assign rt_rem_h[0]  = pre_qh;
	assign rt_root_h[0] = '0;

	// One stage per root bit, most significant first.
	for (genvar g = 0; g < RW; g++) begin : g_root
		rwq_sqrt_stage #(
			.QW    (QW),
			.RW    (RW),
			.BIT   (RW - 1 - g),
			.SIDE_W(SIDE_W)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.src_valid (rt_valid[g]),
			.src_side  (rt_side[g]),
			.src_rem_w (rt_rem_w[g]),
			.src_root_w(rt_root_w[g]),
			.src_rem_h (rt_rem_h[g]),
			.src_root_h(rt_root_h[g]),
			.dst_valid (rt_valid[g+1]),
			.dst_side  (rt_side[g+1]),
			.dst_rem_w (rt_rem_w[g+1]),
			.dst_root_w(rt_root_w[g+1]),
			.dst_rem_h (rt_rem_h[g+1]),
			.dst_root_h(rt_root_h[g+1])
		);
	end

	// Final remainders are not needed; unpack the side data.
	assign {bk_op, bk_sx, bk_sy} = rt_side[RW];

	// Height floor, expansion and frame clamp.
	rwq_window #(
		.SW  (SW),
		.RW  (RW),
		.FRAC(COORD_FRAC_BITS)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.src_valid (rt_valid[RW]),
		.src_op    (bk_op),
		.src_sx    (bk_sx),
		.src_sy    (bk_sy),
		.src_wlen  (rt_root_w[RW]),
		.src_hlen  (rt_root_h[RW]),
		.dst_valid (done),
		.dst_result(result)
	);

	// Every result comes from an item taken earlier at the pipeline input.
	`ASSERT_HOLDS(a_done_has_item, clk, arst_n, done |-> $past(accept, LAT))
	// Every item taken produces its result, no drop.
	`ASSERT_HOLDS(a_item_gives_done, clk, arst_n, accept |-> ##LAT done)
	// A full-frame request opens at the origin.
	`ASSERT_HOLDS(a_full_frame, clk, arst_n,
		(done && $past(accept && item.op, LAT)) |-> (result.left == '0 && result.top == '0))
	// Expansion is never negative, so edges keep their order.
	`ASSERT_NEVER(a_edge_order, clk, arst_n,
		done && (result.left > result.right || result.top > result.bottom))

endmodule

[dv/roi_window_from_quad_top_test.sv]
// -----------------------------------------------------------------------------
// roi_window_from_quad_top_test
// Self-checking bench for the quad-to-search-window block. A queue-fed driver
// sends corner sets and full-frame requests with random gaps. A monitor
// compares every window against an in-bench fixed-point predictor. The run
// steps through several register settings, the extremes among them.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module roi_window_from_quad_top_test;

	import rwq_pkg::*;

	// Bench copy of the block's default fixed-point format.
	localparam int FRAC_BITS      = 4;
	localparam int EDGE_SHIFT     = FRAC_BITS + 5;
	localparam int MAX_COORD      = (1 << COORD_W) - 1;
	localparam int NUM_PHASES     = 6;
	localparam int RANDOM_ITEMS   = 200;
	// Longer than the pipe plus a config pause, far below a hang.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 40;

	logic                  clk    = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start  = 1'b0;
	logic                  busy;
	item_t                 item   = '0;
	logic                  done;
	result_t               result;
	logic                  cfg_we   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Register shadow used by the predictor; only changes while the pipe is empty.
	cfg_t    window_cfg;
	item_t   pending_items[$];
	result_t expected_windows[$];
	result_t predicted_window;
	result_t oldest_window;
	int      gap_pct;
	int      items_queued;
	int      windows_checked;
	int      full_frame_items;
	int      quiet_cycles;
	int      error_count;

	roi_window_from_quad_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------

	// Floor square root by greedy bit setting, MSB first.
	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	// Drop to whole pixels, then clamp to [0, lim]. Negatives go straight to 0.
	function automatic logic [PIX_W-1:0] clamp_edge(longint v, logic [PIX_W-1:0] lim);
		longint p;
		if (v < 0)
			return '0;
		p = v >>> EDGE_SHIFT;
		if (p > longint'(lim))
			return lim;
		return p[PIX_W-1:0];
	endfunction

	function automatic result_t predict_window(item_t it, cfg_t c);
		result_t r;
		int      x0, y0, x1, y1, x2, y2, x3, y3;
		longint  wdx, wdy, hdx, hdy, sx, sy, ox, oy;
		longint unsigned wlen, hlen, hmin;
		if (it.op) begin
			r.left   = '0;
			r.top    = '0;
			r.right  = c.frame_width;
			r.bottom = c.frame_height;
			return r;
		end
		x0 = int'(it.c0_x); y0 = int'(it.c0_y);
		x1 = int'(it.c1_x); y1 = int'(it.c1_y);
		x2 = int'(it.c2_x); y2 = int'(it.c2_y);
		x3 = int'(it.c3_x); y3 = int'(it.c3_y);
		// Corner sum, lifted by 3 bits to the edge resolution.
		sx = longint'(x0 + x1 + x2 + x3) * 8;
		sy = longint'(y0 + y1 + y2 + y3) * 8;
		// Full edge differences; their root is the edge length at one more frac bit.
		wdx = longint'(x1 + x2 - x0 - x3);
		wdy = longint'(y1 + y2 - y0 - y3);
		hdx = longint'(x2 + x3 - x1 - x0);
		hdy = longint'(y2 + y3 - y1 - y0);
		wlen = floor_root(longint'(wdx * wdx + wdy * wdy));
		hlen = floor_root(longint'(hdx * hdx + hdy * hdy));
		hmin = longint'(c.min_height_px) << (FRAC_BITS + 1);
		if (hlen < hmin)
			hlen = hmin;
		ox = wlen * c.width_scale;
		oy = hlen * c.height_scale;
		r.left   = clamp_edge(sx - ox, c.frame_width);
		r.top    = clamp_edge(sy - oy, c.frame_height);
		r.right  = clamp_edge(sx + ox, c.frame_width);
		r.bottom = clamp_edge(sy + oy, c.frame_height);
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	function automatic logic [COORD_W-1:0] clip_coord(int v);
		if (v < 0)
			return '0;
		if (v > MAX_COORD)
			return '1;
		return v[COORD_W-1:0];
	endfunction

	// Quad around (cx, cy) with half sizes hw, hh; sk shears the corners so the
	// edges are not axis-aligned. All values in raw Q11.4 units.
	function automatic item_t quad_item(int cx, int cy, int hw, int hh, int sk);
		item_t it;
		it.op   = 1'b0;
		it.c0_x = clip_coord(cx - hw + sk);
		it.c0_y = clip_coord(cy - hh);
		it.c1_x = clip_coord(cx + hw + sk);
		it.c1_y = clip_coord(cy - hh + sk);
		it.c2_x = clip_coord(cx + hw - sk);
		it.c2_y = clip_coord(cy + hh);
		it.c3_x = clip_coord(cx - hw - sk);
		it.c3_y = clip_coord(cy + hh - sk);
		return it;
	endfunction

	// Mostly plausible detections with random geometry; the rest is raw noise
	// and full-frame requests.
	function automatic item_t random_item();
		item_t        it;
		logic [127:0] noise;
		int           sel;
		int           cx, cy, hw, hh, sk;
		sel = $urandom_range(0, 99);
		if (sel < 28) begin
			noise = {$urandom(), $urandom(), $urandom(), $urandom()};
			it = noise[$bits(item_t)-1:0];
			it.op = (sel < 8);
			return it;
		end
		cx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_COORD)
		                                 : $urandom_range(0, 20479);
		cy = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_COORD)
		                                 : $urandom_range(0, 16383);
		hw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 1600);
		hh = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 1600);
		sk = $urandom_range(0, 8) == 0 ? 0 : int'($urandom_range(0, 256)) - 128;
		return quad_item(cx, cy, hw, hh, sk);
	endfunction

	task automatic check_edge(string name, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	// Write one register at the next edge and mirror it into the shadow.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		case (idx)
			CFG_WIDTH_SCALE:   window_cfg.width_scale   = data[SCALE_W-1:0];
			CFG_HEIGHT_SCALE:  window_cfg.height_scale  = data[SCALE_W-1:0];
			CFG_MIN_HEIGHT_PX: window_cfg.min_height_px = data[PIX_W-1:0];
			CFG_FRAME_WIDTH:   window_cfg.frame_width   = data[PIX_W-1:0];
			CFG_FRAME_HEIGHT:  window_cfg.frame_height  = data[PIX_W-1:0];
			default: ;
		endcase
	endtask

	// ---------------------------------------------------------------------
	// Driver: hold the item until it is taken, then advance or idle.
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item  <= '0;
		end else begin
			// Taken at this edge: predict with the registers as they stand now.
			if (start && !busy) begin
				predicted_window = predict_window(item, window_cfg);
				expected_windows.push_back(predicted_window);
				if (item.op)
					full_frame_items++;
			end
			// Only move on once the current item is gone; a stalled item holds.
			if (!start || !busy) begin
				if (pending_items.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
					start <= 1'b1;
					item  <= pending_items.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: each done pulse is one window, taken at the edge ending it.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (expected_windows.size() == 0) begin
					$error("window with no item outstanding: %p", result);
					error_count++;
				end else begin
					oldest_window = expected_windows.pop_front();
					check_edge("left",   oldest_window.left,   result.left);
					check_edge("top",    oldest_window.top,    result.top);
					check_edge("right",  oldest_window.right,  result.right);
					check_edge("bottom", oldest_window.bottom, result.bottom);
					windows_checked++;
				end
			end
			// Watchdog: count cycles where neither side moves an item.
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no item moved for %0d cycles, %0d windows outstanding",
				         quiet_cycles, expected_windows.size());
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Sequencer: reset, then one phase per register setting.
	// ---------------------------------------------------------------------
	initial begin
		window_cfg.width_scale   = RST_WIDTH_SCALE;
		window_cfg.height_scale  = RST_HEIGHT_SCALE;
		window_cfg.min_height_px = RST_MIN_HEIGHT_PX;
		window_cfg.frame_width   = RST_FRAME_WIDTH;
		window_cfg.frame_height  = RST_FRAME_HEIGHT;
		gap_pct          = 19;
		items_queued     = 0;
		windows_checked  = 0;
		full_frame_items = 0;
		quiet_cycles     = 0;
		error_count      = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			// Sender gaps: light first, heavy next, none at the end.
			gap_pct = (ph < 2) ? 19 : (ph < 4) ? 51 : 0;

			// Phase 0 runs on the reset values; every later phase rewrites all
			// five registers. Pipe is empty here, so writes are safe.
			if (ph != 0) begin
				case (ph)
					1: begin
						// Widest horizontal ratio, no vertical expansion, biggest frame.
						write_reg(CFG_WIDTH_SCALE,   11'd255);
						write_reg(CFG_HEIGHT_SCALE,  11'd0);
						write_reg(CFG_MIN_HEIGHT_PX, 11'd0);
						write_reg(CFG_FRAME_WIDTH,   11'd2047);
						write_reg(CFG_FRAME_HEIGHT,  11'd2047);
					end
					2: begin
						// Opposite corner: no horizontal ratio, huge minimum, 1x1 frame.
						write_reg(CFG_WIDTH_SCALE,   11'd0);
						write_reg(CFG_HEIGHT_SCALE,  11'd255);
						write_reg(CFG_MIN_HEIGHT_PX, 11'd2047);
						write_reg(CFG_FRAME_WIDTH,   11'd1);
						write_reg(CFG_FRAME_HEIGHT,  11'd1);
					end
					3: begin
						// Zero-sized frame: every edge must clamp to 0.
						write_reg(CFG_WIDTH_SCALE,   11'd16);
						write_reg(CFG_HEIGHT_SCALE,  11'd16);
						write_reg(CFG_MIN_HEIGHT_PX, 11'd1);
						write_reg(CFG_FRAME_WIDTH,   11'd0);
						write_reg(CFG_FRAME_HEIGHT,  11'd0);
					end
					default: begin
						write_reg(CFG_WIDTH_SCALE,   CFG_DATA_W'($urandom_range(0, 255)));
						write_reg(CFG_HEIGHT_SCALE,  CFG_DATA_W'($urandom_range(0, 255)));
						write_reg(CFG_MIN_HEIGHT_PX, CFG_DATA_W'($urandom_range(0, 2047)));
						write_reg(CFG_FRAME_WIDTH,   CFG_DATA_W'($urandom_range(1, 2047)));
						write_reg(CFG_FRAME_HEIGHT,  CFG_DATA_W'($urandom_range(1, 2047)));
					end
				endcase
				@(posedge clk);
				cfg_we <= 1'b0;
			end

			// Fill the queue away from the clock edge the driver pops on.
			@(negedge clk);
			if (ph == 0) begin
				// Full-frame requests: the corners must not matter.
				pending_items.push_back({1'b1, {8{15'h1234}}});
				pending_items.push_back({1'b1, {8{15'h7fff}}});
				// All-zero and all-max corners; the second runs off the frame.
				pending_items.push_back('0);
				pending_items.push_back({1'b0, {8{15'h7fff}}});
				// Ordinary box mid-frame.
				pending_items.push_back(quad_item(640 * 16, 512 * 16, 50 * 16, 30 * 16, 0));
				// Degenerate quad: zero width, left and right on the center column.
				pending_items.push_back(quad_item(640 * 16, 512 * 16, 0, 0, 0));
				// Near the origin: left and top go negative.
				pending_items.push_back(quad_item(5 * 16, 5 * 16, 20 * 16, 10 * 16, 0));
				// Near the far corner: right and bottom pass the frame.
				pending_items.push_back(quad_item(1275 * 16, 1020 * 16, 20 * 16, 10 * 16, 0));
				// Alternating bit patterns in every coordinate.
				pending_items.push_back({1'b0, {4{15'h5555, 15'h2aaa}}});
				pending_items.push_back({1'b0, {4{15'h2aaa, 15'h5555}}});
				// Irregular quad with sheared edges.
				pending_items.push_back({1'b0, 15'd1600, 15'd3200, 15'd14400, 15'd2400,
				                         15'd15200, 15'd11200, 15'd1280, 15'd12160});
				// Mirrored winding: difference vectors point negative.
				pending_items.push_back(quad_item(640 * 16, 512 * 16, -(80 * 16), -(40 * 16), 0));
				// Tall box, height above the minimum.
				pending_items.push_back(quad_item(300 * 16, 500 * 16, 10 * 16, 200 * 16, 37));
				// Fractional center with odd sub-pixel bits.
				pending_items.push_back(quad_item(10255, 8199, 333, 517, -9));
				items_queued += 14;
			end
			for (int n = 0; n < RANDOM_ITEMS; n++) begin
				pending_items.push_back(random_item());
				items_queued++;
			end

			// Drain: every queued item has produced its window.
			while (windows_checked != items_queued)
				@(posedge clk);
		end

		// Let any stray trailing pulse show up before the verdict.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_windows.size() != 0) begin
			$error("%0d windows never arrived", expected_windows.size());
			error_count++;
		end
		$display("Checked %0d windows from %0d items (%0d full-frame)",
		         windows_checked, items_queued, full_frame_items);
		$display("across %0d register settings.", NUM_PHASES);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
